// ----- rtl/d2d_pkg.sv -----
// Shared types and constants for the direct 2D DFT engine.
// Holds the Q1.15 sine base table and the quadrant lookup.
// No dependencies.
package d2d_pkg;

  localparam int MAX_LOG  = 6;
  localparam int IDX_W    = 6;
  localparam int ADDR_W   = 12;
  localparam int SAMP_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 48;
  localparam int LOG_W    = 3;
  localparam int PHASE_W  = 9;
  localparam int OUT_W    = 16;

  localparam logic [LOG_W-1:0] LOG_RESET = 3'd6;

  typedef logic [128:0][15:0] sine_tab_t;

  // control from the sequencer into the sample store / MAC pipeline
  typedef struct packed {
    logic                      clear;
    logic                      wr_en;
    logic                      issue;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [SAMP_W-1:0]  wr_data;
    logic [ADDR_W-1:0]         rd_addr;
    logic [PHASE_W-1:0]        phase;
  } d2d_ctl_t;

  // quarter-wave table: sin(2*pi*j/512), Q30 Taylor series, rounded to Q15
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    int          j;
    int          i;
    tab = '0;
    for (j = 0; j <= 128; j++) begin
      x = (64'(j) * 64'd3373259426 + 64'd128) >> 8;
      term = x;
      sum = longint'(x);
      for (i = 1; i <= 12; i++) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 64'((2 * i) * (2 * i + 1));
        if ((i & 1) != 0)
          sum = sum - longint'(term);
        else
          sum = sum + longint'(term);
      end
      if (sum < 0)
        sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767)
        sum = 32767;
      tab[j] = 16'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // sine over 512 points from the quarter-wave table
  function automatic logic signed [15:0] sin_at(input logic [PHASE_W-1:0] p);
    logic [7:0]         idx;
    logic signed [15:0] v;
    if (p[7])
      idx = 8'd128 - {1'b0, p[6:0]};
    else
      idx = {1'b0, p[6:0]};
    v = signed'(SINE_TAB[idx]);
    return p[8] ? -v : v;
  endfunction

endpackage

// ----- rtl/direct_2d_dft.sv -----
// Direct 2D DFT engine, top level: request sequencer, rounding and output register.
// Depends on d2d_pkg and d2d_core.
//
// Usage:
//   cmd channel (cmd_valid/cmd_stall) carries func, row, col, sample.
//   func = 0 stores sample at [row, col] (both masked to N-1); no result.
//   func = 1 computes F[row, col] scaled by 1/N^2 and returns real_part and
//   imag_part on the rsp channel (rsp_valid/rsp_stall).
//   cfg channel (cfg_valid/cfg_ready, always ready) writes size_log2; values
//   below 1 act as 1, above 6 act as 6. Write it only while the block is idle.
// Operation:
//   a compute request walks all N*N stored samples, one per cycle, through the
//   single RAM read port and one complex MAC before its response is valid.
//   cmd_stall stays high until the result is loaded into the output register,
//   where the response sits, so the next request is taken while it waits; a
//   finished compute holds until that register is free.
// Reset (rst, synchronous): clears control state and sets size_log2 to 6.
//   Sample contents are undefined until written.
module direct_2d_dft (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic                                func,
  input  logic [d2d_pkg::IDX_W-1:0]           row,
  input  logic [d2d_pkg::IDX_W-1:0]           col,
  input  logic signed [d2d_pkg::SAMP_W-1:0]   sample,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [d2d_pkg::OUT_W-1:0]    real_part,
  output logic signed [d2d_pkg::OUT_W-1:0]    imag_part,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [d2d_pkg::LOG_W-1:0]           cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_RND   = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam int RW = d2d_pkg::ACC_W + 1;

  logic [2:0]                        state;
  logic [d2d_pkg::LOG_W-1:0]         size_log2;
  logic [d2d_pkg::LOG_W-1:0]         lg;
  logic [d2d_pkg::IDX_W-1:0]         mask;
  logic [4:0]                        sh;
  logic [d2d_pkg::IDX_W-1:0]         k;
  logic [d2d_pkg::IDX_W-1:0]         l;
  logic [d2d_pkg::IDX_W-1:0]         m;
  logic [d2d_pkg::IDX_W-1:0]         c;
  logic [d2d_pkg::IDX_W-1:0]         t;
  logic [11:0]                       km;
  logic [11:0]                       lc;
  logic                              cmd_acc;
  logic                              rsp_free;
  logic signed [RW-1:0]              half;
  logic signed [RW-1:0]              rnd_re;
  logic signed [RW-1:0]              rnd_im;
  logic                              core_busy;
  logic signed [d2d_pkg::ACC_W-1:0]  acc_re;
  logic signed [d2d_pkg::ACC_W-1:0]  acc_im;
  d2d_pkg::d2d_ctl_t                 ctl;

  function automatic logic signed [d2d_pkg::OUT_W-1:0] sat16(input logic signed [RW-1:0] v);
    if (v > RW'(32767))
      return 16'sh7fff;
    else if (v < -RW'(32768))
      return 16'sh8000;
    else
      return v[d2d_pkg::OUT_W-1:0];
  endfunction

  always_comb begin
    if (size_log2 < 3'd1)
      lg = 3'd1;
    else if (size_log2 > 3'(d2d_pkg::MAX_LOG))
      lg = 3'(d2d_pkg::MAX_LOG);
    else
      lg = size_log2;
  end

  assign mask = 6'((7'd1 << lg) - 7'd1);
  assign sh   = {1'b0, lg, 1'b0} + 5'd15;
  assign half = RW'(1) <<< (sh - 5'd1);

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;

  // phase (k*m + l*c) mod N, scaled onto the 512-point table
  assign km = 12'(k) * 12'(m);
  assign lc = 12'(l) * 12'(c);
  assign t  = 6'(km + lc) & mask;

  always_comb begin
    ctl         = '0;
    ctl.clear   = cmd_acc && func;
    ctl.wr_en   = cmd_acc && !func;
    ctl.wr_addr = {row & mask, col & mask};
    ctl.wr_data = sample;
    ctl.issue   = (state == ST_WALK);
    ctl.rd_addr = {m, c};
    ctl.phase   = 9'({3'b000, t} << (4'd9 - {1'b0, lg}));
  end

  d2d_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .busy   (core_busy),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      size_log2 <= d2d_pkg::LOG_RESET;
      rsp_valid <= 1'b0;
      m         <= '0;
      c         <= '0;
    end else begin
      if (cfg_valid && cfg_ready)
        size_log2 <= cfg_data;

      if (state == ST_OUT && rsp_free)
        rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall)
        rsp_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (cmd_acc && func) begin
            m     <= '0;
            c     <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (c == mask) begin
            c <= '0;
            if (m == mask)
              state <= ST_DRAIN;
            else
              m <= m + 6'd1;
          end else begin
            c <= c + 6'd1;
          end
        end
        ST_DRAIN: begin
          if (!core_busy)
            state <= ST_RND;
        end
        ST_RND:   state <= ST_SHIFT;
        ST_SHIFT: state <= ST_OUT;
        ST_OUT: begin
          if (rsp_free)
            state <= ST_IDLE;
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_acc && func) begin
      k <= row & mask;
      l <= col & mask;
    end
    if (state == ST_RND) begin
      rnd_re <= RW'(acc_re) + half;
      rnd_im <= RW'(acc_im) + half;
    end else if (state == ST_SHIFT) begin
      // floor after adding half: round half towards plus infinity
      rnd_re <= rnd_re >>> sh;
      rnd_im <= rnd_im >>> sh;
    end
    if (state == ST_OUT && rsp_free) begin
      real_part <= sat16(rnd_re);
      imag_part <= sat16(rnd_im);
    end
  end

endmodule

// ----- rtl/d2d_core.sv -----
// Sample store and complex multiply-accumulate pipeline.
// One synchronous RAM (registered read) feeding twiddle lookup, multiply, accumulate.
// Depends on d2d_pkg.
module d2d_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  d2d_pkg::d2d_ctl_t                      ctl,
  output logic                                   busy,
  output logic signed [d2d_pkg::ACC_W-1:0]       acc_re,
  output logic signed [d2d_pkg::ACC_W-1:0]       acc_im
);

  localparam int DEPTH = 1 << d2d_pkg::ADDR_W;

  logic signed [d2d_pkg::SAMP_W-1:0] mem [DEPTH];

  logic signed [d2d_pkg::SAMP_W-1:0] rdata;
  logic [d2d_pkg::PHASE_W-1:0]       phase1;
  logic                              v1;
  logic signed [d2d_pkg::SAMP_W-1:0] samp2;
  logic signed [15:0]                cos2;
  logic signed [15:0]                nsin2;
  logic                              v2;
  logic signed [d2d_pkg::PROD_W-1:0] prod_re;
  logic signed [d2d_pkg::PROD_W-1:0] prod_im;
  logic                              v3;

  // writes only happen while no walk is running, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (ctl.wr_en)
      mem[ctl.wr_addr] <= ctl.wr_data;
    if (ctl.issue)
      rdata <= mem[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    phase1  <= ctl.phase;
    samp2   <= rdata;
    cos2    <= d2d_pkg::sin_at(phase1 + d2d_pkg::PHASE_W'(128));
    nsin2   <= -d2d_pkg::sin_at(phase1);
    prod_re <= samp2 * cos2;
    prod_im <= samp2 * nsin2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      acc_re <= '0;
      acc_im <= '0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      if (ctl.clear) begin
        acc_re <= '0;
        acc_im <= '0;
      end else if (v3) begin
        acc_re <= acc_re + d2d_pkg::ACC_W'(prod_re);
        acc_im <= acc_im + d2d_pkg::ACC_W'(prod_im);
      end
    end
  end

  assign busy = v1 | v2 | v3;

endmodule

// ----- sim/d2d_tb_pkg.sv -----
// Request codes shared by the 2D DFT testbench top and its checker.
// No dependencies.
package d2d_tb_pkg;

  typedef enum logic {
    OP_STORE     = 1'b0,
    OP_TRANSFORM = 1'b1
  } op_t;

endpackage

// ----- sim/direct_2d_dft_checker.sv -----
// Scoreboard for the direct 2D DFT engine: mirrors the sample matrix and size,
// predicts each transform bin in Q1.15 and compares it with the response channel.
// Depends on d2d_pkg and d2d_tb_pkg.
module direct_2d_dft_checker
  import d2d_pkg::*;
  import d2d_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  logic                     cmd_stall,
  input  logic                     func,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [SAMP_W-1:0] sample,
  input  logic                     rsp_valid,
  input  logic                     rsp_stall,
  input  logic signed [OUT_W-1:0]  real_part,
  input  logic signed [OUT_W-1:0]  imag_part,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [LOG_W-1:0]         cfg_data,
  output int                       fault_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } spectrum_t;

  logic signed [SAMP_W-1:0] sample_mem [0:63][0:63];
  longint                   quarter_sine [0:128];
  logic [LOG_W-1:0]         size_reg;
  spectrum_t                expected_bins [$];

  // quarter wave of sin(2*pi*j/512): Taylor series in Q30, rounded to Q15
  initial begin : sine_init
    bit [63:0] ang;
    bit [63:0] pw;
    longint    acc;
    int        j;
    int        i;
    for (j = 0; j <= 128; j++) begin
      ang = (64'(j) * 64'd3373259426 + 64'd128) >> 8;
      pw  = ang;
      acc = longint'(ang);
      for (i = 1; i <= 12; i++) begin
        pw = (pw * ang) >> 30;
        pw = ((pw * ang) >> 30) / 64'((2 * i) * (2 * i + 1));
        if (i % 2 == 1)
          acc = acc - longint'(pw);
        else
          acc = acc + longint'(pw);
      end
      if (acc < 0)
        acc = 0;
      acc = (acc + 16384) >>> 15;
      if (acc > 32767)
        acc = 32767;
      quarter_sine[j] = acc;
    end
  end

  function automatic int unsigned active_log();
    if (size_reg < 1)
      return 1;
    if (size_reg > MAX_LOG)
      return MAX_LOG;
    return size_reg;
  endfunction

  function automatic longint sine512(input logic [8:0] ph);
    longint v;
    v = ph[7] ? quarter_sine[128 - ph[6:0]] : quarter_sine[ph[6:0]];
    return ph[8] ? -v : v;
  endfunction

  // rounding half up is a floor after adding half an lsb
  function automatic logic signed [OUT_W-1:0] round_sat(input logic [ACC_W-1:0] acc,
                                                        input int unsigned sh);
    longint s;
    s = longint'(signed'(acc)) + (longint'(1) << (sh - 1));
    s = s >>> sh;
    if (s > 32767)
      s = 32767;
    else if (s < -32768)
      s = -32768;
    return OUT_W'(s);
  endfunction

  function automatic spectrum_t dft_bin(input logic [IDX_W-1:0] k_raw,
                                        input logic [IDX_W-1:0] l_raw);
    int unsigned      lg;
    int unsigned      msk;
    int unsigned      k;
    int unsigned      l;
    int unsigned      m;
    int unsigned      c;
    int unsigned      ph;
    longint           f;
    logic [ACC_W-1:0] acc_re;
    logic [ACC_W-1:0] acc_im;
    spectrum_t        bin;
    lg     = active_log();
    msk    = (1 << lg) - 1;
    k      = k_raw & msk;
    l      = l_raw & msk;
    acc_re = '0;
    acc_im = '0;
    for (m = 0; m <= msk; m++) begin
      for (c = 0; c <= msk; c++) begin
        ph     = (((k * m + l * c) & msk) << (9 - lg)) & 511;
        f      = longint'(sample_mem[m][c]);
        acc_re = acc_re + ACC_W'(f * sine512(9'((ph + 128) & 511)));
        acc_im = acc_im - ACC_W'(f * sine512(9'(ph)));
      end
    end
    bin.re = round_sat(acc_re, 2 * lg + 15);
    bin.im = round_sat(acc_im, 2 * lg + 15);
    return bin;
  endfunction

  task automatic log_fault(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fault_count++;
  endtask

  always @(posedge clk) begin : watch
    spectrum_t   want;
    int unsigned msk;
    if (rst) begin
      size_reg = LOG_RESET;
      expected_bins.delete();
      fault_count = 0;
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_bins.size() == 0) begin
          log_fault($sformatf("response re=%0d im=%0d with no request waiting",
                              real_part, imag_part));
        end else begin
          want = expected_bins.pop_front();
          if (real_part !== want.re)
            log_fault($sformatf("real_part got %0d want %0d", real_part, want.re));
          if (imag_part !== want.im)
            log_fault($sformatf("imag_part got %0d want %0d", imag_part, want.im));
        end
      end
      if (cfg_valid && cfg_ready)
        size_reg = cfg_data;
      if (cmd_valid && !cmd_stall) begin
        msk = (1 << active_log()) - 1;
        if (func == OP_STORE)
          sample_mem[row & msk][col & msk] = sample;
        else
          expected_bins.push_back(dft_bin(row, col));
      end
      pending <= expected_bins.size();
    end
  end

endmodule

// ----- sim/direct_2d_dft_tb.sv -----
// Testbench top for direct_2d_dft: drives store and transform requests, size
// writes and response stalls; the checker does prediction and comparison.
// Depends on d2d_pkg, d2d_tb_pkg, direct_2d_dft_checker and the RTL.
module direct_2d_dft_tb;
  import d2d_pkg::*;
  import d2d_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 4200;
  localparam logic [7:0][LOG_W-1:0] SIZE_PLAN =
    {3'd1, 3'd3, 3'd0, 3'd2, 3'd3, 3'd1, 3'd2, 3'd0};

  typedef enum int {PACE_FULL, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cmd_valid = 1'b0;
  logic                     cmd_stall;
  logic                     func = OP_STORE;
  logic [IDX_W-1:0]         row = '0;
  logic [IDX_W-1:0]         col = '0;
  logic signed [SAMP_W-1:0] sample = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [OUT_W-1:0]  real_part;
  logic signed [OUT_W-1:0]  imag_part;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [LOG_W-1:0]         cfg_data = '0;

  int    fault_count;
  int    pending;
  int    quiet_cycles = 0;
  pace_t pace = PACE_FULL;

  direct_2d_dft dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .func      (func),
    .row       (row),
    .col       (col),
    .sample    (sample),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .real_part (real_part),
    .imag_part (imag_part),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  direct_2d_dft_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .func        (func),
    .row         (row),
    .col         (col),
    .sample      (sample),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .real_part   (real_part),
    .imag_part   (imag_part),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    case (pace)
      PACE_RECV: rsp_stall <= ($urandom_range(99) < 81);
      PACE_BOTH: rsp_stall <= ($urandom_range(99) < 6);
      default:   rsp_stall <= 1'b0;
    endcase
  end

  // watchdog: reports TB_ERROR and stops when the quiet count reaches STALL_LIMIT
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMP_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  task automatic issue_request(input op_t op, input logic [IDX_W-1:0] r,
                               input logic [IDX_W-1:0] c,
                               input logic signed [SAMP_W-1:0] s);
    int gap_pct;
    gap_pct = (pace == PACE_SEND) ? 81 : (pace == PACE_BOTH) ? 6 : 0;
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    func      <= op;
    row       <= r;
    col       <= c;
    sample    <= s;
    @(posedge clk);
    while (cmd_stall)
      @(posedge clk);
  endtask

  task automatic random_request(input int transform_pct);
    op_t op;
    op = ($urandom_range(99) < transform_pct) ? OP_TRANSFORM : OP_STORE;
    issue_request(op, IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)),
                  random_sample());
  endtask

  // all responses in, then an idle margin for a trailing store request
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_size(input logic [LOG_W-1:0] lg);
    cfg_valid <= 1'b1;
    cfg_data  <= lg;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int r;
    int c;
    int ph;
    int pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 8x8 corner at the reset size; every later size is 8 or smaller, so no
    // read hits an unwritten entry
    for (r = 0; r < 8; r++)
      for (c = 0; c < 8; c++)
        issue_request(OP_STORE, IDX_W'(r), IDX_W'(c), random_sample());
    settle();
    set_size(3'd3);
    issue_request(OP_STORE, 6'd13, 6'd58, random_sample());
    issue_request(OP_TRANSFORM, 6'd0, 6'd0, random_sample());
    issue_request(OP_TRANSFORM, 6'd63, 6'd63, random_sample());
    issue_request(OP_TRANSFORM, 6'd32, 6'd17, random_sample());

    // size 0 acts as 2x2; high indices wrap onto the small matrix
    settle();
    set_size(3'd0);
    issue_request(OP_STORE, 6'd0, 6'd0, 16'sd32767);
    issue_request(OP_STORE, 6'd63, 6'd63, -16'sd32768);
    issue_request(OP_STORE, 6'd62, 6'd1, -16'sd1);
    issue_request(OP_STORE, 6'd1, 6'd62, 16'sd0);
    issue_request(OP_TRANSFORM, 6'd0, 6'd0, 16'sd0);
    issue_request(OP_TRANSFORM, 6'd1, 6'd1, 16'sd0);
    issue_request(OP_TRANSFORM, 6'd63, 6'd62, 16'sd0);
    issue_request(OP_TRANSFORM, 6'd0, 6'd1, 16'sd0);
    // most negative everywhere
    issue_request(OP_STORE, 6'd0, 6'd0, -16'sd32768);
    issue_request(OP_STORE, 6'd0, 6'd1, -16'sd32768);
    issue_request(OP_STORE, 6'd1, 6'd0, -16'sd32768);
    issue_request(OP_STORE, 6'd1, 6'd1, -16'sd32768);
    issue_request(OP_TRANSFORM, 6'd0, 6'd0, 16'sd0);
    issue_request(OP_TRANSFORM, 6'd1, 6'd1, 16'sd0);

    settle();
    set_size(3'd1);
    issue_request(OP_TRANSFORM, 6'd1, 6'd0, 16'sd0);

    // random phases, one size and one pacing each
    for (ph = 0; ph < 8; ph++) begin
      settle();
      pace = pace_t'(ph % 4);
      set_size(SIZE_PLAN[ph]);
      pct = (SIZE_PLAN[ph] == 3'd3) ? 30 : 45;
      repeat (7) random_request(pct);
    end

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
